// File: rtl/hll_pkg.sv
// Shared constants, command record and helper function for the sketch update engine.
package hll_pkg;

  localparam int MAX_PRECISION_DEF = 14;
  localparam int MIN_PRECISION     = 4;
  localparam int PREC_W            = 5;
  localparam int RANK_W            = 6;
  localparam int CAP_W             = 7;

  localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(14);

  localparam logic CFG_PRECISION = 1'b0;
  localparam logic CFG_SEED      = 1'b1;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_MERGE = 1'b1;

  localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;
  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [63:0] FIN_MUL1  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FIN_MUL2  = 64'hc4ceb9fe1a85ec53;

  typedef struct packed {
    logic                cmd;
    logic [7:0]          data_byte;
    logic                has_byte;
    logic                last;
    logic [RANK_W-1:0]   merge_rank;
  } cmd_t;

  // Leading zeros of a nonzero byte.
  function automatic logic [2:0] lz8(input logic [7:0] v);
    logic [2:0] n;
    logic       hit;
    n   = 3'd0;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && !v[i]) begin
        n = n + 3'd1;
      end else begin
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: rtl/hyperloglog_sketch_update.sv
// Top level of the HyperLogLog insert and merge engine.
// A merge reads the rank store, then updates it; each byte runs one 64-bit multiply (from three
// 32x32 partial products); an item's first byte adds seed mixing before it, its closing byte adds
// finalizing, a leading-zero search (8 bits a cycle) and the rank store read and update.
// Throughput is set by the shared multiplier; a two-entry queue takes commands ahead; results
// cannot be stalled. Reset and a precision write clear all 2**MAX_PRECISION entries of the store.
module hyperloglog_sketch_update
  import hll_pkg::*;
#(
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd,
  input  logic [7:0]               data_byte,
  input  logic                     has_byte,
  input  logic                     last,
  input  logic [MAX_PRECISION-1:0] merge_index,
  input  logic [RANK_W-1:0]        merge_rank,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [63:0]              cfg_data,
  output logic                     done,
  output logic [MAX_PRECISION-1:0] reg_index,
  output logic [RANK_W-1:0]        stored_rank,
  output logic                     changed,
  output logic [MAX_PRECISION:0]   zero_count
);

  logic [PREC_W-1:0]        prec;
  logic [63:0]              seed;
  logic                     clr_req;
  logic                     clearing;
  logic                     pop;
  logic                     head_valid;
  cmd_t                     head_cmd;
  logic [MAX_PRECISION-1:0] head_idx;
  cmd_t                     in_cmd;
  logic [PREC_W-1:0]        prec_wr;

  // Clamp the written precision into the supported range.
  always_comb begin
    prec_wr = {1'b0, cfg_data[3:0]};
    if (prec_wr < PREC_W'(MIN_PRECISION)) prec_wr = PREC_W'(MIN_PRECISION);
    if (prec_wr > PREC_W'(MAX_PRECISION)) prec_wr = PREC_W'(MAX_PRECISION);
  end

  // A precision write wipes the rank store and drops any item in progress.
  assign clr_req = cfg_we && (cfg_index == CFG_PRECISION);

  always_ff @(posedge clk) begin
    if (rst) begin
      prec <= (PREC_RESET > PREC_W'(MAX_PRECISION)) ? PREC_W'(MAX_PRECISION) : PREC_RESET;
      seed <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PRECISION) prec <= prec_wr;
      else seed <= cfg_data;
    end
  end

  assign in_cmd = '{cmd: cmd, data_byte: data_byte, has_byte: has_byte,
                    last: last, merge_rank: merge_rank};

  hll_front #(.MAX_PRECISION(MAX_PRECISION)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .clearing   (clearing),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .in_idx     (merge_index),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_idx   (head_idx)
  );

  hll_back #(.MAX_PRECISION(MAX_PRECISION)) u_back (
    .clk         (clk),
    .rst         (rst),
    .clr_req     (clr_req),
    .prec        (prec),
    .seed        (seed),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .head_idx    (head_idx),
    .pop         (pop),
    .clearing    (clearing),
    .done        (done),
    .reg_index   (reg_index),
    .stored_rank (stored_rank),
    .changed     (changed),
    .zero_count  (zero_count)
  );

endmodule

// File: rtl/hll_front.sv
// Front end: accepts commands, drops idle adds and queues the rest.
module hll_front
  import hll_pkg::*;
#(
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     clearing,
  output logic                     busy,
  input  cmd_t                     in_cmd,
  input  logic [MAX_PRECISION-1:0] in_idx,
  input  logic                     pop,
  output logic                     head_valid,
  output cmd_t                     head_cmd,
  output logic [MAX_PRECISION-1:0] head_idx
);

  cmd_t                     q_cmd [2];
  logic [MAX_PRECISION-1:0] q_idx [2];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               count;
  logic                     accept;
  logic                     push;

  assign busy   = (count == 2'd2) || clearing;
  assign accept = start && !busy;
  // Drop an add that carries no byte and does not close the item.
  assign push   = accept && !(in_cmd.cmd == CMD_ADD && !in_cmd.has_byte && !in_cmd.last);

  assign head_valid = (count != 2'd0);
  assign head_cmd   = q_cmd[rd_ptr];
  assign head_idx   = q_idx[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr] <= in_cmd;
      q_idx[wr_ptr] <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/hll_mul.sv
// 64-bit low-half multiplier built from three 32x32 partial products.
module hll_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LL   = 3'd1;
  localparam logic [2:0] ST_LH   = 3'd2;
  localparam logic [2:0] ST_HL   = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;

  logic [2:0]  step;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] lo_p;
  logic [31:0] mid;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] m;

  always_comb begin
    case (step)
      ST_LH:   begin op_a = a_r[31:0];  op_b = b_r[63:32]; end
      ST_HL:   begin op_a = a_r[63:32]; op_b = b_r[31:0];  end
      default: begin op_a = a_r[31:0];  op_b = b_r[31:0];  end
    endcase
  end

  assign m = {32'd0, op_a} * {32'd0, op_b};

  always_ff @(posedge clk) begin
    if (go) begin
      a_r <= a;
      b_r <= b;
    end
    case (step)
      ST_LL:   lo_p <= m;
      ST_LH:   mid  <= m[31:0];
      ST_HL:   mid  <= mid + m[31:0];
      ST_SUM:  p    <= {lo_p[63:32] + mid, lo_p[31:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= (step == ST_SUM);
      case (step)
        ST_IDLE: if (go) step <= ST_LL;
        ST_LL:   step <= ST_LH;
        ST_LH:   step <= ST_HL;
        ST_HL:   step <= ST_SUM;
        default: step <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/hll_back.sv
// Back end: hashing sequencer, rank search and rank store update.
module hll_back
  import hll_pkg::*;
#(
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr_req,
  input  logic [PREC_W-1:0]        prec,
  input  logic [63:0]              seed,
  input  logic                     head_valid,
  input  cmd_t                     head_cmd,
  input  logic [MAX_PRECISION-1:0] head_idx,
  output logic                     pop,
  output logic                     clearing,
  output logic                     done,
  output logic [MAX_PRECISION-1:0] reg_index,
  output logic [RANK_W-1:0]        stored_rank,
  output logic                     changed,
  output logic [MAX_PRECISION:0]   zero_count
);

  localparam int DEPTH = 1 << MAX_PRECISION;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SM1    = 4'd2;
  localparam logic [3:0] S_SM2    = 4'd3;
  localparam logic [3:0] S_SEEDED = 4'd4;
  localparam logic [3:0] S_BYTE   = 4'd5;
  localparam logic [3:0] S_AFTER  = 4'd6;
  localparam logic [3:0] S_FIN1   = 4'd7;
  localparam logic [3:0] S_FIN2   = 4'd8;
  localparam logic [3:0] S_FIN3   = 4'd9;
  localparam logic [3:0] S_LZ     = 4'd10;
  localparam logic [3:0] S_READ   = 4'd11;
  localparam logic [3:0] S_UPD    = 4'd12;
  localparam logic [3:0] S_MWAIT  = 4'd13;

  logic [RANK_W-1:0]        mem [DEPTH];
  logic [RANK_W-1:0]        rd_q;
  logic [3:0]               state;
  logic [3:0]               ret;
  logic [MAX_PRECISION-1:0] clr_addr;
  logic [63:0]              acc;
  logic [63:0]              running_hash;
  logic                     in_item;
  cmd_t                     cur;
  logic [63:0]              rest;
  logic [CAP_W-1:0]         lz_cnt;
  logic [MAX_PRECISION-1:0] idx;
  logic [RANK_W-1:0]        rank;
  logic [MAX_PRECISION:0]   zeros_left;

  logic                     mul_go;
  logic [63:0]              mul_a;
  logic [63:0]              mul_b;
  logic                     mul_done;
  logic [63:0]              mul_p;

  logic [CAP_W-1:0]         cap;
  logic [63:0]              fin_h;
  logic [CAP_W-1:0]         lz_total;
  logic                     lz_fin;
  logic [CAP_W-1:0]         rank_full;
  logic [MAX_PRECISION-1:0] idx_mask;
  logic                     inc;
  logic                     mem_we;
  logic [MAX_PRECISION-1:0] mem_wa;
  logic [RANK_W-1:0]        mem_wd;

  hll_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  assign cap      = CAP_W'(65) - CAP_W'(prec);
  assign idx_mask = MAX_PRECISION'((65'd1 << prec) - 65'd1);
  assign fin_h    = acc ^ (acc >> 33);
  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && head_valid;
  assign inc      = rank > rd_q;

  always_comb begin
    lz_fin   = 1'b1;
    lz_total = lz_cnt + CAP_W'(lz8(rest[63:56]));
    if (rest[63:56] == 8'd0) begin
      lz_total = lz_cnt + CAP_W'(8);
      lz_fin   = (lz_cnt == CAP_W'(56));
    end
    rank_full = lz_total + CAP_W'(1);
  end

  always_comb begin
    mul_go = 1'b0;
    mul_a  = fin_h;
    mul_b  = FIN_MUL1;
    case (state)
      S_SM1: begin
        mul_go = 1'b1;
        mul_a  = acc ^ (acc >> 30);
        mul_b  = SM_MUL1;
      end
      S_SM2: begin
        mul_go = 1'b1;
        mul_a  = acc ^ (acc >> 27);
        mul_b  = SM_MUL2;
      end
      S_BYTE: begin
        mul_go = cur.has_byte;
        mul_a  = acc ^ {56'd0, cur.data_byte};
        mul_b  = FNV_PRIME;
      end
      S_FIN1: mul_go = 1'b1;
      S_FIN2: begin
        mul_go = 1'b1;
        mul_b  = FIN_MUL2;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_UPD && inc) begin
      mem_we = 1'b1;
      mem_wa = idx;
      mem_wd = rank;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[idx];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (head_valid) begin
        cur <= head_cmd;
        idx <= head_idx & idx_mask;
        acc <= in_item ? running_hash : seed + SM_GOLDEN;
        if (head_cmd.merge_rank > RANK_W'(cap)) rank <= RANK_W'(cap);
        else rank <= head_cmd.merge_rank;
      end
      S_MWAIT:  if (mul_done) acc <= mul_p;
      S_SEEDED: acc <= acc ^ (acc >> 31) ^ FNV_BASIS;
      S_AFTER:  if (!cur.last) running_hash <= acc;
      S_FIN3: begin
        idx    <= MAX_PRECISION'(fin_h >> (7'd64 - CAP_W'(prec)));
        rest   <= fin_h << prec;
        lz_cnt <= '0;
      end
      S_LZ: begin
        if (lz_fin) begin
          rank <= (rank_full > cap) ? RANK_W'(cap) : RANK_W'(rank_full);
        end else begin
          lz_cnt <= lz_total;
          rest   <= rest << 8;
        end
      end
      default: ;
    endcase
    if (state == S_UPD) begin
      reg_index   <= idx;
      stored_rank <= inc ? rank : rd_q;
      changed     <= inc;
      zero_count  <= (inc && rd_q == '0) ? zeros_left - 1'b1 : zeros_left;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst || clr_req) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      in_item  <= 1'b0;
      done     <= 1'b0;
      ret      <= S_IDLE;
    end else begin
      done <= (state == S_UPD);
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MAX_PRECISION'(DEPTH - 1)) begin
            zeros_left <= (MAX_PRECISION+1)'(1) << prec;
            state      <= S_IDLE;
          end
        end
        S_IDLE: if (head_valid) begin
          if (head_cmd.cmd == CMD_MERGE) begin
            state <= S_READ;
          end else begin
            state   <= in_item ? S_BYTE : S_SM1;
            in_item <= !head_cmd.last;
          end
        end
        S_SM1:    begin ret <= S_SM2;    state <= S_MWAIT; end
        S_SM2:    begin ret <= S_SEEDED; state <= S_MWAIT; end
        S_SEEDED: state <= S_BYTE;
        S_BYTE: begin
          if (cur.has_byte) begin
            ret   <= S_AFTER;
            state <= S_MWAIT;
          end else begin
            state <= S_FIN1;
          end
        end
        S_AFTER:  state <= cur.last ? S_FIN1 : S_IDLE;
        S_FIN1:   begin ret <= S_FIN2; state <= S_MWAIT; end
        S_FIN2:   begin ret <= S_FIN3; state <= S_MWAIT; end
        S_FIN3:   state <= S_LZ;
        S_LZ:     if (lz_fin) state <= S_READ;
        S_READ:   state <= S_UPD;
        S_UPD: begin
          if (inc && rd_q == '0) zeros_left <= zeros_left - 1'b1;
          state <= S_IDLE;
        end
        S_MWAIT:  if (mul_done) state <= ret;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
